/* rtl/core/mte_pkg.sv */
// marker table engine: shared types, command codes and datapath operation codes
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package mte_pkg;

   localparam int MAX_MARKERS_DEFAULT = 64;

   localparam int FUNC_W = 4;
   localparam int POS_W  = 32;
   localparam int IDX_W  = 10;
   localparam int DLT_W  = 16;
   localparam int LVL_W  = 17;
   localparam int CSR_IDX_W = 1;

   localparam int Q_FRAC = 16;
   localparam logic [LVL_W-1:0] Q_ONE = LVL_W'(1 << Q_FRAC);

   localparam int MOD_STEPS = LVL_W;

   localparam logic [FUNC_W-1:0] FN_ADD      = 4'd0;
   localparam logic [FUNC_W-1:0] FN_CLEAR    = 4'd1;
   localparam logic [FUNC_W-1:0] FN_REMOVE   = 4'd2;
   localparam logic [FUNC_W-1:0] FN_FIND     = 4'd3;
   localparam logic [FUNC_W-1:0] FN_BOUNDS   = 4'd4;
   localparam logic [FUNC_W-1:0] FN_SHIFT    = 4'd5;
   localparam logic [FUNC_W-1:0] FN_KEEP     = 4'd6;
   localparam logic [FUNC_W-1:0] FN_JOIN     = 4'd7;
   localparam logic [FUNC_W-1:0] FN_ORGANIZE = 4'd8;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_REEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOL  = 1'd1;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 5'd1;
   localparam logic [OP_W-1:0] OP_ADD       = 5'd2;
   localparam logic [OP_W-1:0] OP_CLEAR     = 5'd3;
   localparam logic [OP_W-1:0] OP_IGNORE    = 5'd4;
   localparam logic [OP_W-1:0] OP_RMV_INIT  = 5'd5;
   localparam logic [OP_W-1:0] OP_JOIN_INIT = 5'd6;
   localparam logic [OP_W-1:0] OP_RMV_PRE   = 5'd7;
   localparam logic [OP_W-1:0] OP_RMV_SHIFT = 5'd8;
   localparam logic [OP_W-1:0] OP_RMV_END   = 5'd9;
   localparam logic [OP_W-1:0] OP_FIND_PRE  = 5'd10;
   localparam logic [OP_W-1:0] OP_FIND_CMP  = 5'd11;
   localparam logic [OP_W-1:0] OP_BND_SEL   = 5'd12;
   localparam logic [OP_W-1:0] OP_BND_RD1   = 5'd13;
   localparam logic [OP_W-1:0] OP_BND_CALC  = 5'd14;
   localparam logic [OP_W-1:0] OP_KEEP_W0   = 5'd15;
   localparam logic [OP_W-1:0] OP_KEEP_W1   = 5'd16;
   localparam logic [OP_W-1:0] OP_MOD_INIT  = 5'd17;
   localparam logic [OP_W-1:0] OP_MOD_STEP  = 5'd18;
   localparam logic [OP_W-1:0] OP_MOD_END   = 5'd19;
   localparam logic [OP_W-1:0] OP_ORG_MUL   = 5'd20;
   localparam logic [OP_W-1:0] OP_ORG_END   = 5'd21;
   localparam logic [OP_W-1:0] OP_EMIT      = 5'd22;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              empty;
      logic              lt2;
      logic              rmv_ok;
      logic              last;
      logic              last2;
      logic              match;
      logic              mod_last;
   } dp_stat_type;

endpackage

`default_nettype wire

/* rtl/core/mte_ctrl.sv */
// marker table engine: command sequencer and result handshake
// depends on mte_pkg
`default_nettype none

module mte_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   input  wire mte_pkg::dp_stat_type   stat,
   output logic [mte_pkg::OP_W-1:0]    op
);
   import mte_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_RCHK  = 4'd2;
   localparam logic [3:0] S_RSH   = 4'd3;
   localparam logic [3:0] S_REND  = 4'd4;
   localparam logic [3:0] S_FCMP  = 4'd5;
   localparam logic [3:0] S_BRD1  = 4'd6;
   localparam logic [3:0] S_BCALC = 4'd7;
   localparam logic [3:0] S_KW0   = 4'd8;
   localparam logic [3:0] S_KW1   = 4'd9;
   localparam logic [3:0] S_MOD   = 4'd10;
   localparam logic [3:0] S_MEND  = 4'd11;
   localparam logic [3:0] S_ORG   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      op = OP_NONE;
      valid_in = valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            state_in = S_DONE;
            case (stat.func)
               FN_ADD: op = OP_ADD;
               FN_CLEAR: op = OP_CLEAR;
               FN_REMOVE: begin
                  if (stat.rmv_ok) begin
                     op = OP_RMV_INIT;
                     state_in = S_RCHK;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               FN_JOIN: begin
                  if (!stat.lt2) begin
                     op = OP_JOIN_INIT;
                     state_in = S_RCHK;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               FN_FIND: begin
                  if (!stat.empty) begin
                     op = OP_FIND_PRE;
                     state_in = S_FCMP;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               FN_BOUNDS: begin
                  op = OP_BND_SEL;
                  state_in = S_BRD1;
               end
               FN_KEEP: begin
                  if (!stat.empty) begin
                     op = OP_BND_SEL;
                     state_in = S_BRD1;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               FN_SHIFT: begin
                  if (!stat.empty) begin
                     op = OP_MOD_INIT;
                     state_in = S_MOD;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               FN_ORGANIZE: begin
                  if (!stat.empty) begin
                     op = OP_ORG_MUL;
                     state_in = S_ORG;
                  end else begin
                     op = OP_IGNORE;
                  end
               end
               default: op = OP_IGNORE;
            endcase
         end
         S_RCHK: begin
            if (stat.last) begin
               op = OP_RMV_END;
               state_in = S_DONE;
            end else begin
               op = OP_RMV_PRE;
               state_in = S_RSH;
            end
         end
         S_RSH: begin
            op = OP_RMV_SHIFT;
            if (stat.last2) begin
               state_in = S_REND;
            end
         end
         S_REND: begin
            op = OP_RMV_END;
            state_in = S_DONE;
         end
         S_FCMP: begin
            op = OP_FIND_CMP;
            if (stat.match || stat.last) begin
               state_in = S_DONE;
            end
         end
         S_BRD1: begin
            op = OP_BND_RD1;
            state_in = S_BCALC;
         end
         S_BCALC: begin
            op = OP_BND_CALC;
            state_in = (stat.func == FN_KEEP) ? S_KW0 : S_DONE;
         end
         S_KW0: begin
            op = OP_KEEP_W0;
            state_in = S_KW1;
         end
         S_KW1: begin
            op = OP_KEEP_W1;
            state_in = S_DONE;
         end
         S_MOD: begin
            op = OP_MOD_STEP;
            if (stat.mod_last) begin
               state_in = S_MEND;
            end
         end
         S_MEND: begin
            op = OP_MOD_END;
            state_in = S_DONE;
         end
         S_ORG: begin
            op = OP_ORG_END;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!valid_ff || !rsp_stall) begin
               op = OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

`default_nettype wire

/* rtl/core/mte_datapath.sv */
// marker table engine: marker memory, count, current index, arithmetic and result register
// depends on mte_pkg; driven by mte_ctrl through operation codes
`default_nettype none

module mte_datapath #(
   parameter int MAX_MARKERS = mte_pkg::MAX_MARKERS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [mte_pkg::OP_W-1:0]        op,
   output mte_pkg::dp_stat_type           stat,
   input  wire [mte_pkg::FUNC_W-1:0]      req_func,
   input  wire [mte_pkg::POS_W-1:0]       req_position,
   input  wire signed [mte_pkg::IDX_W-1:0] req_index,
   input  wire signed [mte_pkg::DLT_W-1:0] req_delta,
   input  wire [mte_pkg::LVL_W-1:0]       req_level,
   input  wire                            csr_write,
   input  wire [mte_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [31:0]                     csr_data,
   output logic [1:0]                     rsp_status,
   output logic [5:0]                     rsp_found_index,
   output logic [31:0]                    rsp_bound_start,
   output logic [31:0]                    rsp_bound_end,
   output logic [6:0]                     rsp_marker_count,
   output logic [5:0]                     rsp_current_index
);
   import mte_pkg::*;

   localparam int CW = $clog2(MAX_MARKERS + 1);
   localparam int IW = $clog2(MAX_MARKERS);
   localparam int PW = LVL_W + CW;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_MARKERS);

   logic [POS_W-1:0] mem [MAX_MARKERS];
   logic [POS_W-1:0] rdata_ff;
   logic             we;
   logic [IW-1:0]    waddr, raddr;
   logic [POS_W-1:0] wdata;

   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     k_ff, k_in;
   logic [IW-1:0]     right_ff, right_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [DLT_W-1:0]  dlt_ff, dlt_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [31:0]       reel_ff, reel_in, tol_ff, tol_in;
   logic [1:0]        wst_ff, wst_in;
   logic [IW-1:0]     wfi_ff, wfi_in;
   logic [31:0]       first_ff, first_in;
   logic [31:0]       seg_s_ff, seg_s_in, seg_e_ff, seg_e_in;
   logic              neg_ff, neg_in;
   logic [LVL_W-1:0]  mag_ff, mag_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [4:0]        mcnt_ff, mcnt_in;
   logic [PW-1:0]     prod_ff, prod_in;

   logic [CW:0]       kx, cntx, curx;
   logic [CW-1:0]     cnt_m1;
   logic [31:0]       gap, s0, e0;
   logic [IW-1:0]     sel;
   logic [17:0]       tsum;
   logic [CW:0]       rem2;
   logic [LVL_W-1:0]  lvlc;
   logic [CW:0]       quo;
   logic [CW-1:0]     cnt_n;
   logic [IW-1:0]     cur_c;

   assign kx = (CW+1)'(k_ff);
   assign cntx = (CW+1)'(cnt_ff);
   assign curx = (CW+1)'(cur_ff);
   assign cnt_m1 = cnt_ff - CW'(1);
   assign gap = (pos_ff > rdata_ff) ? pos_ff - rdata_ff : rdata_ff - pos_ff;

   assign stat.func = func_ff;
   assign stat.empty = (cnt_ff == '0);
   assign stat.lt2 = (cntx < (CW+1)'(2));
   assign stat.rmv_ok = !idx_ff[IDX_W-1] && (32'(idx_ff[IDX_W-2:0]) < 32'(cnt_ff));
   assign stat.last = (kx + (CW+1)'(1)) >= cntx;
   assign stat.last2 = (kx + (CW+1)'(2)) >= cntx;
   assign stat.match = (gap <= tol_ff);
   assign stat.mod_last = (mcnt_ff == 5'd1);

   always_comb begin
      if (func_ff == FN_KEEP) begin
         sel = cur_ff;
      end else if (idx_ff[IDX_W-1]) begin
         sel = '0;
      end else if (32'(idx_ff[IDX_W-2:0]) >= 32'(cnt_ff)) begin
         sel = IW'(cnt_m1);
      end else begin
         sel = IW'(idx_ff[IDX_W-2:0]);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      cur_in = cur_ff;
      k_in = k_ff;
      right_in = right_ff;
      func_in = func_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      dlt_in = dlt_ff;
      lvl_in = lvl_ff;
      reel_in = reel_ff;
      tol_in = tol_ff;
      wst_in = wst_ff;
      wfi_in = wfi_ff;
      first_in = first_ff;
      seg_s_in = seg_s_ff;
      seg_e_in = seg_e_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      rem_in = rem_ff;
      mcnt_in = mcnt_ff;
      prod_in = prod_ff;
      we = 1'b0;
      waddr = k_ff;
      wdata = rdata_ff;
      raddr = IW'(kx + (CW+1)'(1));
      s0 = '0;
      e0 = '0;
      tsum = '0;
      rem2 = '0;
      lvlc = '0;
      quo = '0;
      cnt_n = '0;
      cur_c = '0;

      if (csr_write) begin
         case (csr_index)
            REG_REEL: reel_in = csr_data;
            REG_TOL: tol_in = csr_data;
            default: ;
         endcase
      end

      case (op)
         OP_LOAD: begin
            func_in = req_func;
            pos_in = req_position;
            idx_in = req_index;
            dlt_in = req_delta;
            lvl_in = req_level;
            wst_in = ST_OK;
            wfi_in = '0;
         end
         OP_ADD: begin
            if (cnt_ff == CNT_MAX) begin
               wst_in = ST_FULL;
            end else begin
               we = 1'b1;
               waddr = IW'(cnt_ff);
               wdata = pos_ff;
               cnt_in = cnt_ff + CW'(1);
            end
         end
         OP_CLEAR: begin
            cnt_in = '0;
            cur_in = '0;
         end
         OP_IGNORE: wst_in = ST_IGNORED;
         OP_RMV_INIT: k_in = IW'(idx_ff[IDX_W-2:0]);
         OP_JOIN_INIT: begin
            right_in = ((curx + (CW+1)'(1)) == cntx) ? '0 : IW'(curx + (CW+1)'(1));
            k_in = right_in;
         end
         OP_RMV_PRE: raddr = IW'(kx + (CW+1)'(1));
         OP_RMV_SHIFT: begin
            we = 1'b1;
            raddr = IW'(kx + (CW+1)'(2));
            k_in = IW'(kx + (CW+1)'(1));
         end
         OP_RMV_END: begin
            cnt_n = cnt_m1;
            if (cnt_n == '0) begin
               cur_c = '0;
            end else if (curx >= (CW+1)'(cnt_n)) begin
               cur_c = IW'(cnt_n - CW'(1));
            end else begin
               cur_c = cur_ff;
            end
            if (func_ff == FN_JOIN && right_ff <= cur_c && cur_c != '0) begin
               cur_c = cur_c - IW'(1);
            end
            cnt_in = cnt_n;
            cur_in = cur_c;
         end
         OP_FIND_PRE: begin
            k_in = '0;
            raddr = '0;
         end
         OP_FIND_CMP: begin
            if (stat.match) begin
               wfi_in = k_ff;
            end else if (stat.last) begin
               wst_in = ST_NOTFOUND;
            end else begin
               k_in = IW'(kx + (CW+1)'(1));
            end
         end
         OP_BND_SEL: begin
            k_in = sel;
            raddr = sel;
         end
         OP_BND_RD1: first_in = rdata_ff;
         OP_BND_CALC: begin
            s0 = (first_ff >= reel_ff) ? '0 : first_ff;
            if (stat.last) begin
               e0 = reel_ff;
            end else begin
               e0 = (rdata_ff > reel_ff) ? reel_ff : rdata_ff;
            end
            if (cnt_ff == '0 || reel_ff == '0 || s0 >= e0) begin
               seg_s_in = '0;
               seg_e_in = reel_ff;
            end else begin
               seg_s_in = s0;
               seg_e_in = e0;
            end
         end
         OP_KEEP_W0: begin
            we = 1'b1;
            waddr = '0;
            wdata = '0;
         end
         OP_KEEP_W1: begin
            if ((curx + (CW+1)'(1)) < cntx) begin
               we = 1'b1;
               waddr = IW'(1);
               wdata = seg_e_ff - seg_s_ff;
               cnt_in = CW'(2);
            end else begin
               cnt_in = CW'(1);
            end
            cur_in = '0;
         end
         OP_MOD_INIT: begin
            tsum = {{2{dlt_ff[DLT_W-1]}}, dlt_ff} + 18'(cur_ff);
            neg_in = tsum[17];
            mag_in = tsum[17] ? LVL_W'(~tsum + 18'd1) : tsum[LVL_W-1:0];
            rem_in = '0;
            mcnt_in = 5'(MOD_STEPS);
         end
         OP_MOD_STEP: begin
            rem2 = {rem_ff, mag_ff[LVL_W-1]};
            if (rem2 >= cntx) begin
               rem_in = CW'(rem2 - cntx);
            end else begin
               rem_in = CW'(rem2);
            end
            mag_in = {mag_ff[LVL_W-2:0], 1'b0};
            mcnt_in = mcnt_ff - 5'd1;
         end
         OP_MOD_END: begin
            if (neg_ff && rem_ff != '0) begin
               cur_in = IW'(cnt_ff - rem_ff);
            end else begin
               cur_in = IW'(rem_ff);
            end
         end
         OP_ORG_MUL: begin
            lvlc = (lvl_ff > Q_ONE) ? Q_ONE : lvl_ff;
            prod_in = PW'(lvlc) * PW'(cnt_m1);
         end
         OP_ORG_END: begin
            quo = prod_ff[PW-1:Q_FRAC];
            cur_in = (quo >= cntx) ? IW'(cnt_m1) : IW'(quo);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         cur_ff <= '0;
         reel_ff <= '0;
         tol_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         cur_ff <= cur_in;
         reel_ff <= reel_in;
         tol_ff <= tol_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
      right_ff <= right_in;
      func_ff <= func_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      dlt_ff <= dlt_in;
      lvl_ff <= lvl_in;
      wst_ff <= wst_in;
      wfi_ff <= wfi_in;
      first_ff <= first_in;
      seg_s_ff <= seg_s_in;
      seg_e_ff <= seg_e_in;
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      mcnt_ff <= mcnt_in;
      prod_ff <= prod_in;
      if (op == OP_EMIT) begin
         rsp_status <= wst_ff;
         rsp_found_index <= 6'(wfi_ff);
         rsp_bound_start <= (func_ff == FN_BOUNDS) ? seg_s_ff : '0;
         rsp_bound_end <= (func_ff == FN_BOUNDS) ? seg_e_ff : '0;
         rsp_marker_count <= 7'(cnt_ff);
         rsp_current_index <= 6'(cur_ff);
      end
   end

endmodule

`default_nettype wire

/* rtl/core/marker_table_engine.sv */
// marker table engine top level: joins the sequencer and the datapath
// depends on mte_pkg, mte_ctrl, mte_datapath
//
// usage: one command item enters on the req_ channel (valid/stall) and gives
// exactly one result item on the rsp_ channel. req_stall is high while a
// command is in progress; the block works on one item at a time.
// csr_write with csr_index writes reel length (0) or match tolerance (1);
// the user must write these only while no command is in progress, since the
// block itself does not enforce it.
// remove and join right shift each later marker down one place in the marker
// memory; find inspects the markers in order until one matches or the last
// is reached; shift uses a 17-step remainder unit and organize one multiply
// stage.
// the result sits in an output register: the next command is taken while it
// waits, and the sequencer holds its next result until rsp_stall drops.
// reset clears the count, the current index, both registers and rsp_valid.
`default_nettype none

module marker_table_engine #(
   parameter int MAX_MARKERS = mte_pkg::MAX_MARKERS_DEFAULT
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire [mte_pkg::FUNC_W-1:0]      req_func,
   input  wire [mte_pkg::POS_W-1:0]       req_position,
   input  wire signed [mte_pkg::IDX_W-1:0] req_index,
   input  wire signed [mte_pkg::DLT_W-1:0] req_delta,
   input  wire [mte_pkg::LVL_W-1:0]       req_level,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [5:0]                     rsp_found_index,
   output logic [31:0]                    rsp_bound_start,
   output logic [31:0]                    rsp_bound_end,
   output logic [6:0]                     rsp_marker_count,
   output logic [5:0]                     rsp_current_index,
   input  wire                            csr_write,
   input  wire [mte_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [31:0]                     csr_data
);
   import mte_pkg::*;

   dp_stat_type     stat;
   logic [OP_W-1:0] op;

   mte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .op        (op)
   );

   mte_datapath #(
      .MAX_MARKERS (MAX_MARKERS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .stat              (stat),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_index         (req_index),
      .req_delta         (req_delta),
      .req_level         (req_level),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_status        (rsp_status),
      .rsp_found_index   (rsp_found_index),
      .rsp_bound_start   (rsp_bound_start),
      .rsp_bound_end     (rsp_bound_end),
      .rsp_marker_count  (rsp_marker_count),
      .rsp_current_index (rsp_current_index)
   );

endmodule

`default_nettype wire
